>>> src/assert_macros.svh
// Assertion macros for the RTL of the column L2 normalizer.
// Defining NO_ASSERTIONS compiles every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CLN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`define CLN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define CLN_ASSERT_IMPL(label, clk, rst, ante, cons)

`define CLN_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/cln_pkg.sv
// Package of the column L2 normalizer: payload types, codes and widths.
// It depends on nothing; cln_norm_div and the core import it.
`default_nettype none

package cln_pkg;

   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 64;

   localparam int ELEM_W     = 16;
   localparam int SUM_W      = 40;
   localparam int SQ_W       = 32;
   localparam int NORM_W     = 20;
   localparam int QUO_W      = 16;
   localparam int ROOT_STEPS = 20;
   localparam int STEP_CNT_W = 5;

   localparam int ROWS_W     = 9;
   localparam int COLS_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd256;
   localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd1;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_NORM = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   localparam logic [QUO_W-1:0] Q15_MAX     = 16'h7FFF;
   localparam logic [QUO_W-1:0] Q15_MIN     = 16'h8000;
   localparam logic [QUO_W-1:0] Q15_NEG_MAG = 16'h8000;

   typedef struct packed {
      logic [1:0]               func;
      logic [7:0]               row_index;
      logic [5:0]               col_index;
      logic signed [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [QUO_W-1:0] normalized_value;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  sum;
      logic [ELEM_W-1:0] element;
   } nd_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] value;
   } nd_rsp_type;

endpackage

`default_nettype wire

>>> src/cln_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing.
`default_nettype none

module cln_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire  logic             clock,
   input  wire  logic             wr_en,
   input  wire  logic [AW-1:0]    wr_addr,
   input  wire  logic [WIDTH-1:0] wr_data,
   input  wire  logic             rd_en,
   input  wire  logic [AW-1:0]    rd_addr,
   output logic       [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/cln_norm_div.sv
// Bit-serial norm unit: square root of a column sum, two radicand bits per
// cycle, then a restoring divide of the element by that norm, one quotient
// bit per cycle, with Q1.15 saturation. Depends on cln_pkg.
`default_nettype none

module cln_norm_div import cln_pkg::*; (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  nd_req_type nd_req,
   output nd_rsp_type       nd_rsp
);

   typedef enum logic [3:0] {
      ND_IDLE = 4'b0001,
      ND_ROOT = 4'b0010,
      ND_DIV  = 4'b0100,
      ND_DONE = 4'b1000
   } nd_state_type;

   localparam logic [STEP_CNT_W-1:0] ROOT_LAST = STEP_CNT_W'(ROOT_STEPS - 1);
   localparam logic [STEP_CNT_W-1:0] DIV_LAST  = STEP_CNT_W'(QUO_W - 1);

   nd_state_type state_ff, state_in;

   logic [SUM_W-1:0]      rad_ff, rad_in;
   logic [NORM_W+1:0]     rem_ff, rem_in;
   logic [NORM_W-1:0]     root_ff, root_in;
   logic [NORM_W-1:0]     drem_ff, drem_in;
   logic [QUO_W-1:0]      dsh_ff, dsh_in;
   logic [QUO_W-1:0]      q_ff, q_in;
   logic [ELEM_W-1:0]     mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;

   logic [NORM_W+3:0] rem_t;
   logic [NORM_W+3:0] trial;
   logic              root_ge;
   logic [NORM_W:0]   div_t;
   logic [NORM_W:0]   div_d;
   logic              div_ge;
   logic              ovf;
   logic [QUO_W-1:0]  value;
   logic [ELEM_W-1:0] elem_mag;

   always_comb begin
      elem_mag = nd_req.element[ELEM_W-1] ? (~nd_req.element + ELEM_W'(1)) : nd_req.element;

      rem_t   = {rem_ff, rad_ff[SUM_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      root_ge = (rem_t >= trial);

      div_t  = {drem_ff, dsh_ff[QUO_W-1]};
      div_d  = {1'b0, root_ff};
      div_ge = (div_t >= div_d);

      ovf = ({{(NORM_W + 1 - ELEM_W){1'b0}}, mag_ff} >= {root_ff, 1'b0});
      if (neg_ff) begin
         value = (ovf || (q_ff > Q15_NEG_MAG)) ? Q15_MIN : (~q_ff + QUO_W'(1));
      end else begin
         value = (ovf || q_ff[QUO_W-1]) ? Q15_MAX : q_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      drem_in  = drem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;

      unique case (state_ff)
         ND_IDLE: begin
            if (nd_req.start) begin
               rad_in   = nd_req.sum;
               rem_in   = '0;
               root_in  = '0;
               mag_in   = elem_mag;
               neg_in   = nd_req.element[ELEM_W-1];
               cnt_in   = ROOT_LAST;
               state_in = ND_ROOT;
            end
         end
         ND_ROOT: begin
            rad_in  = {rad_ff[SUM_W-3:0], 2'b00};
            rem_in  = root_ge ? (NORM_W+2)'(rem_t - trial) : rem_t[NORM_W+1:0];
            root_in = {root_ff[NORM_W-2:0], root_ge};
            cnt_in  = cnt_ff - STEP_CNT_W'(1);
            if (cnt_ff == '0) begin
               // The divide starts with the dividend's bits above bit 15 in
               // its remainder; the element sits fifteen places up.
               drem_in  = {{(NORM_W - ELEM_W + 1){1'b0}}, mag_ff[ELEM_W-1:1]};
               dsh_in   = {mag_ff[0], {(QUO_W - 1){1'b0}}};
               q_in     = '0;
               cnt_in   = DIV_LAST;
               state_in = ND_DIV;
            end
         end
         ND_DIV: begin
            drem_in = div_ge ? NORM_W'(div_t - div_d) : div_t[NORM_W-1:0];
            dsh_in  = {dsh_ff[QUO_W-2:0], 1'b0};
            q_in    = {q_ff[QUO_W-2:0], div_ge};
            cnt_in  = cnt_ff - STEP_CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ND_DONE;
            end
         end
         ND_DONE: begin
            state_in = ND_IDLE;
         end
         default: begin
            state_in = ND_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ND_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
   end

   assign nd_rsp.done  = (state_ff == ND_DONE);
   assign nd_rsp.value = value;

endmodule

`default_nettype wire

>>> src/column_l2_normalizer_core.sv
// Top level of the column L2 normalizer: item sequencer, element store,
// column sum store and output register. Depends on cln_pkg, cln_ram,
// cln_norm_div and assert_macros.svh.
//
//   Channel  Ports                                  Transfer
//   -------  -------------------------------------  -----------------------
//   request  req_valid, req_ready, req_data         valid and ready high
//   result   rsp_valid, rsp_ready, rsp_data         valid and ready high
//   config   csr_write_en, csr_index, csr_wdata     write enable high
//
// One item is worked on at a time. A read runs the square root of the column sum
// and then the divide. A clear sweeps the column sum RAM, one entry a cycle.
// The next transfer in can come in the same cycle as rsp_valid rises. After reset
// the sweep clears the column sum RAM before the first transfer in. A stalled
// result waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module column_l2_normalizer_core import cln_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  req_valid,
   output logic                        req_ready,
   input  wire  req_type               req_data,
   output logic                        rsp_valid,
   input  wire  logic                  rsp_ready,
   output rsp_type                     rsp_data,
   input  wire  logic                  csr_write_en,
   input  wire  logic [CSR_IDX_W-1:0]  csr_index,
   input  wire  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int EDEPTH = MAX_ROWS * MAX_COLS;
   localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LOOKUP = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_NORM   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   req_type           item_ff, item_in;
   logic              in_range_ff, in_range_in;
   logic [EAW-1:0]    eaddr_ff, eaddr_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [CW-1:0]     sweep_ff, sweep_in;
   rsp_type           result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              sweeping;
   logic              take_result;
   logic              rsp_free;
   logic [31:0]       ea_full;
   logic [31:0]       col_wide;
   logic [CW-1:0]     col_addr;
   logic              req_in_range;
   logic [ELEM_W-1:0] ev;
   logic [ELEM_W-1:0] mag;
   logic [SUM_W:0]    sum_add;
   logic [SUM_W-1:0]  sum_sat;

   logic              srd_en;
   logic              swr_en;
   logic [CW-1:0]     swr_addr;
   logic [SUM_W-1:0]  swr_data;
   logic [SUM_W-1:0]  sum_rd;
   logic              erd_en;
   logic              ewr_en;
   logic [ELEM_W-1:0] elem_rd;

   nd_req_type nd_req;
   nd_rsp_type nd_rsp;

   cln_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_COLS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (swr_en),
      .wr_addr (swr_addr),
      .wr_data (swr_data),
      .rd_en   (srd_en),
      .rd_addr (col_addr),
      .rd_data (sum_rd)
   );

   cln_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (EDEPTH)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (ewr_en),
      .wr_addr (eaddr_ff),
      .wr_data (item_ff.element_value),
      .rd_en   (erd_en),
      .rd_addr (eaddr_ff),
      .rd_data (elem_rd)
   );

   cln_norm_div u_norm_div (
      .clock  (clock),
      .reset  (reset),
      .nd_req (nd_req),
      .nd_rsp (nd_rsp)
   );

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_free  = !rsp_valid_ff || rsp_ready;
      sweeping  = (state_ff == ST_INIT) || (state_ff == ST_SWEEP);

      req_in_range = ({1'b0, req_data.row_index} < rows_ff)
                  && ({5'b0, req_data.row_index} < 13'(MAX_ROWS))
                  && ({1'b0, req_data.col_index} < cols_ff)
                  && ({5'b0, req_data.col_index} < 11'(MAX_COLS));
      ea_full = 32'(req_data.row_index) * 32'(MAX_COLS) + 32'(req_data.col_index);

      col_wide = 32'(item_ff.col_index);
      col_addr = col_wide[CW-1:0];

      ev  = item_ff.element_value;
      mag = ev[ELEM_W-1] ? (~ev + ELEM_W'(1)) : ev;

      sum_add = {1'b0, sum_rd} + (SUM_W+1)'(sq_ff);
      sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

      swr_addr = sweeping ? sweep_ff : col_addr;
      swr_data = sweeping ? '0 : sum_sat;
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_in = csr_wdata[ROWS_W-1:0];
            CSR_COLS_IN_USE: cols_in = csr_wdata[COLS_W-1:0];
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      in_range_in   = in_range_ff;
      eaddr_in      = eaddr_ff;
      sq_in         = sq_ff;
      sweep_in      = sweep_ff;
      result_in     = result_ff;
      srd_en        = 1'b0;
      erd_en        = 1'b0;
      swr_en        = 1'b0;
      ewr_en        = 1'b0;
      take_result   = 1'b0;
      nd_req.start   = 1'b0;
      nd_req.sum     = sum_rd;
      nd_req.element = elem_rd;

      unique case (state_ff)
         ST_INIT: begin
            swr_en   = 1'b1;
            sweep_in = sweep_ff + CW'(1);
            if (sweep_ff == CW'(MAX_COLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               in_range_in = req_in_range;
               eaddr_in    = ea_full[EAW-1:0];
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            result_in.normalized_value = '0;
            result_in.status           = STATUS_OK;
            sq_in                      = SQ_W'(mag) * SQ_W'(mag);
            unique case (item_ff.func)
               FUNC_LOAD: begin
                  if (in_range_ff) begin
                     srd_en   = 1'b1;
                     state_in = ST_CHECK;
                  end else begin
                     result_in.status = STATUS_RANGE;
                     state_in         = ST_FINISH;
                  end
               end
               FUNC_READ: begin
                  if (in_range_ff) begin
                     srd_en   = 1'b1;
                     erd_en   = 1'b1;
                     state_in = ST_CHECK;
                  end else begin
                     result_in.status = STATUS_RANGE;
                     state_in         = ST_FINISH;
                  end
               end
               FUNC_CLEAR: begin
                  sweep_in = '0;
                  state_in = ST_SWEEP;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_CHECK: begin
            if (item_ff.func == FUNC_LOAD) begin
               swr_en   = 1'b1;
               ewr_en   = 1'b1;
               state_in = ST_FINISH;
            end else if (sum_rd == '0) begin
               result_in.status = STATUS_ZERO_NORM;
               state_in         = ST_FINISH;
            end else begin
               nd_req.start = 1'b1;
               state_in     = ST_NORM;
            end
         end
         ST_SWEEP: begin
            swr_en   = 1'b1;
            sweep_in = sweep_ff + CW'(1);
            if (sweep_ff == CW'(MAX_COLS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_NORM: begin
            if (nd_rsp.done) begin
               result_in.normalized_value = nd_rsp.value;
               state_in                   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               take_result = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || take_result;
      rsp_data_in  = take_result ? result_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      in_range_ff <= in_range_in;
      eaddr_ff    <= eaddr_in;
      sq_ff       <= sq_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CLN_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `CLN_ASSERT_IMPL(a_norm_done_while_waiting, clock, reset, nd_rsp.done, state_ff == ST_NORM)
   `CLN_ASSERT_IMPL(a_norm_nonzero_sum, clock, reset, nd_req.start, sum_rd != '0)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for column_l2_normalizer_core: a directed table, then random
// phases over several matrix sizes, checked against an in-bench model of the column norms.
// Depends on cln_pkg and the RTL of the block only.
module tb_top import cln_pkg::*;;

   localparam int MAX_ROWS = MAX_ROWS_DEF;
   localparam int MAX_COLS = MAX_COLS_DEF;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [63:0] SUM_CEILING = (64'd1 << SUM_W) - 64'd1;

   typedef enum logic {STEP_ITEM, STEP_REG} step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      req_type                 item;
      logic                    typed;
      rsp_type                 outcome;
      logic [CSR_IDX_W-1:0]    reg_index;
      logic [CSR_DATA_W-1:0]   reg_value;
   } plan_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic idle_on = 1'b1;
   logic long_hold_req = 1'b0;
   bit   hold_taken;
   int   hold_left;
   int   stall_left;
   int   mismatches;

   bit [ELEM_W-1:0] elem_mem [MAX_ROWS*MAX_COLS];
   bit              elem_loaded [MAX_ROWS*MAX_COLS];
   bit [SUM_W-1:0]  col_energy [MAX_COLS];
   int              rows_limit = 256;
   int              cols_limit = 64;
   int              loaded_addrs [$];
   rsp_type         results_due [$];
   rsp_type         head_due;
   plan_step_type   directed_plan [$];

   column_l2_normalizer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [NORM_W-1:0] floor_root(bit [SUM_W-1:0] v);
      logic [NORM_W-1:0] root;
      logic [63:0] trial;
      int b;
      root = '0;
      for (b = NORM_W - 1; b >= 0; b--) begin
         trial = 64'(root) | (64'd1 << b);
         if (trial * trial <= 64'(v)) root = trial[NORM_W-1:0];
      end
      return root;
   endfunction

   function automatic rsp_type normalize_item(req_type it);
      rsp_type r;
      logic [13:0] addr;
      bit in_range;
      int xi;
      logic [63:0] mag, total, quo;
      logic [NORM_W-1:0] root;
      r = '0;
      r.status = STATUS_OK;
      addr = {it.row_index, it.col_index};
      in_range = int'(it.row_index) < rows_limit && int'(it.row_index) < MAX_ROWS &&
                 int'(it.col_index) < cols_limit && int'(it.col_index) < MAX_COLS;
      case (it.func)
         FUNC_CLEAR: begin
            foreach (col_energy[i]) col_energy[i] = '0;
         end
         FUNC_LOAD: begin
            if (!in_range) begin
               r.status = STATUS_RANGE;
            end else begin
               xi = int'(it.element_value);
               mag = 64'(xi < 0 ? -xi : xi);
               elem_mem[addr] = it.element_value;
               if (!elem_loaded[addr]) begin
                  elem_loaded[addr] = 1'b1;
                  loaded_addrs = {loaded_addrs, int'(addr)};
               end
               total = 64'(col_energy[it.col_index]) + mag * mag;
               col_energy[it.col_index] = (total > SUM_CEILING) ? SUM_CEILING[SUM_W-1:0]
                                                                : total[SUM_W-1:0];
            end
         end
         FUNC_READ: begin
            if (!in_range) begin
               r.status = STATUS_RANGE;
            end else begin
               root = floor_root(col_energy[it.col_index]);
               if (root == '0) begin
                  r.status = STATUS_ZERO_NORM;
               end else begin
                  xi = int'($signed(elem_mem[addr]));
                  mag = 64'(xi < 0 ? -xi : xi) << 15;
                  quo = mag / 64'(root);
                  if (xi < 0) begin
                     if (quo > 64'd32768) quo = 64'd32768;
                     r.normalized_value = 16'(64'd0 - quo);
                  end else begin
                     if (quo > 64'd32767) quo = 64'd32767;
                     r.normalized_value = quo[15:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic [ELEM_W-1:0] draw_element();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 1200)) - 600);
         4: return ($urandom_range(0, 1) == 1) ? 16'h0100 : 16'hFF00;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type pick_item();
      req_type it;
      int roll, tries, pick, row_cap, col_cap;
      logic [13:0] addr;
      row_cap = (rows_limit < MAX_ROWS) ? rows_limit : MAX_ROWS;
      col_cap = (cols_limit < MAX_COLS) ? cols_limit : MAX_COLS;
      it.func = FUNC_LOAD;
      it.row_index = 8'($urandom_range(0, 255));
      it.col_index = 6'($urandom_range(0, 63));
      it.element_value = draw_element();
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         it.func = FUNC_CLEAR;
      end else if (roll < 8) begin
         it.func = FUNC_UNUSED;
      end else if (roll < 18) begin
         if ($urandom_range(0, 1) == 1 &&
             (int'(it.row_index) >= row_cap || int'(it.col_index) >= col_cap ||
              elem_loaded[{it.row_index, it.col_index}]))
            it.func = FUNC_READ;
      end else if (roll < 55 && loaded_addrs.size() != 0) begin
         for (tries = 0; tries < 16; tries++) begin
            pick = $urandom_range(0, loaded_addrs.size() - 1);
            addr = 14'(loaded_addrs[pick]);
            if (int'(addr[13:6]) < row_cap && int'(addr[5:0]) < col_cap) begin
               it.func = FUNC_READ;
               it.row_index = addr[13:6];
               it.col_index = addr[5:0];
               break;
            end
         end
      end else if (row_cap > 0 && col_cap > 0) begin
         it.row_index = 8'($urandom_range(0, row_cap - 1));
         it.col_index = 6'($urandom_range(0, col_cap - 1));
      end
      return it;
   endfunction

   function automatic plan_step_type plan_item(logic [1:0] f, logic [7:0] r, logic [5:0] c,
                                               logic [15:0] v);
      plan_step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.item.func = f;
      s.item.row_index = r;
      s.item.col_index = c;
      s.item.element_value = v;
      return s;
   endfunction

   function automatic plan_step_type plan_known(logic [1:0] f, logic [7:0] r, logic [5:0] c,
                                                logic [15:0] v, logic [15:0] q,
                                                logic [1:0] st);
      plan_step_type s;
      s = plan_item(f, r, c, v);
      s.typed = 1'b1;
      s.outcome.normalized_value = q;
      s.outcome.status = st;
      return s;
   endfunction

   function automatic plan_step_type plan_reg(logic [CSR_IDX_W-1:0] idx,
                                              logic [CSR_DATA_W-1:0] val);
      plan_step_type s;
      s = '0;
      s.kind = STEP_REG;
      s.reg_index = idx;
      s.reg_value = val;
      return s;
   endfunction

   function automatic void add_step(plan_step_type s);
      directed_plan = {directed_plan, s};
   endfunction

   task automatic send_item(input req_type it, input logic typed, input rsp_type known);
      rsp_type due;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      due = normalize_item(it);
      results_due = {results_due, (typed ? known : due)};
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_ROWS_IN_USE) rows_limit = int'(val[8:0]);
      else cols_limit = int'(val[6:0]);
      @(posedge clock);
   endtask

   task automatic set_dims(input int rows, input int cols);
      drain_pipeline();
      write_reg(CSR_ROWS_IN_USE, CSR_DATA_W'(rows));
      write_reg(CSR_COLS_IN_USE, CSR_DATA_W'(cols));
   endtask

   task automatic run_phase(input int count);
      repeat (count) send_item(pick_item(), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer out: value %h status %0d",
                        rsp_data.normalized_value, rsp_data.status);
         end else begin
            head_due = results_due.pop_front();
            if (rsp_data.normalized_value !== head_due.normalized_value ||
                rsp_data.status !== head_due.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %h status %0d, got value %h status %0d",
                           head_due.normalized_value, head_due.status,
                           rsp_data.normalized_value, rsp_data.status);
            end
         end
      end
      if (long_hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int fcol, row;
      add_step(plan_known(FUNC_CLEAR, 8'd0, 6'd0, 16'h0000, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_UNUSED, 8'd255, 6'd63, 16'hFFFF, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_LOAD, 8'd0, 6'd0, 16'h0100, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_READ, 8'd0, 6'd0, 16'h0000, Q15_MAX, STATUS_OK));
      add_step(plan_known(FUNC_LOAD, 8'd1, 6'd1, 16'h8000, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_READ, 8'd1, 6'd1, 16'h0000, Q15_MIN, STATUS_OK));
      add_step(plan_known(FUNC_LOAD, 8'd255, 6'd63, 16'h7FFF, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_READ, 8'd255, 6'd63, 16'h0000, Q15_MAX, STATUS_OK));
      add_step(plan_item(FUNC_LOAD, 8'd2, 6'd0, 16'h0100));
      add_step(plan_item(FUNC_READ, 8'd0, 6'd0, 16'h0000));
      add_step(plan_item(FUNC_READ, 8'd2, 6'd0, 16'h0000));
      add_step(plan_known(FUNC_LOAD, 8'd3, 6'd5, 16'h0000, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_READ, 8'd3, 6'd5, 16'h0000, 16'h0000, STATUS_ZERO_NORM));
      add_step(plan_known(FUNC_LOAD, 8'd4, 6'd5, 16'hFF80, 16'h0000, STATUS_OK));
      add_step(plan_item(FUNC_READ, 8'd3, 6'd5, 16'h0000));
      add_step(plan_known(FUNC_CLEAR, 8'd7, 6'd9, 16'h1234, 16'h0000, STATUS_OK));
      add_step(plan_known(FUNC_READ, 8'd0, 6'd0, 16'h0000, 16'h0000, STATUS_ZERO_NORM));
      add_step(plan_reg(CSR_ROWS_IN_USE, 9'd1));
      add_step(plan_reg(CSR_COLS_IN_USE, 9'd1));
      add_step(plan_known(FUNC_LOAD, 8'd1, 6'd0, 16'h1234, 16'h0000, STATUS_RANGE));
      add_step(plan_known(FUNC_READ, 8'd0, 6'd1, 16'h0000, 16'h0000, STATUS_RANGE));
      add_step(plan_item(FUNC_LOAD, 8'd0, 6'd0, 16'h0001));
      add_step(plan_item(FUNC_READ, 8'd0, 6'd0, 16'h0000));
      add_step(plan_reg(CSR_ROWS_IN_USE, 9'd0));
      add_step(plan_known(FUNC_READ, 8'd0, 6'd0, 16'h0000, 16'h0000, STATUS_RANGE));
      add_step(plan_known(FUNC_LOAD, 8'd0, 6'd0, 16'h4000, 16'h0000, STATUS_RANGE));
      add_step(plan_reg(CSR_ROWS_IN_USE, 9'h1FF));
      add_step(plan_reg(CSR_COLS_IN_USE, 9'd127));
      add_step(plan_item(FUNC_READ, 8'd0, 6'd0, 16'h0000));
      add_step(plan_item(FUNC_LOAD, 8'd255, 6'd63, 16'h8001));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_REG) begin
            drain_pipeline();
            write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].outcome);
         end
      end

      set_dims(256, 64);
      long_hold_req <= 1'b1;
      run_phase(150);
      set_dims(1, 1);
      run_phase(60);
      set_dims($urandom_range(1, 12), $urandom_range(1, 6));
      run_phase(100);
      repeat (4) begin
         set_dims($urandom_range(0, 511), $urandom_range(0, 127));
         run_phase(25);
      end

      // Full-scale loads into one column build up a large sum of squares.
      set_dims(256, 64);
      send_item(plan_item(FUNC_CLEAR, 8'd0, 6'd0, 16'h0000).item, 1'b0, '0);
      fcol = $urandom_range(0, 63);
      repeat (120)
         send_item(plan_item(FUNC_LOAD, 8'($urandom_range(0, 255)), 6'(fcol), 16'h8000).item,
                   1'b0, '0);
      repeat (40) begin
         row = $urandom_range(0, 255);
         if (elem_loaded[{8'(row), 6'(fcol)}])
            send_item(plan_item(FUNC_READ, 8'(row), 6'(fcol), 16'h0000).item, 1'b0, '0);
      end
      run_phase(60);

      set_dims($urandom_range(64, 256), $urandom_range(16, 64));
      idle_on <= 1'b0;
      run_phase(120);

      drain_pipeline();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
